[rtl/hsv_color_shader_core_macros.svh]
// ----------------------------------------------------------------------------
// HSV colour shader assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_SHADER_CORE_MACROS_SVH
`define HSV_COLOR_SHADER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define HSVCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Checked on every clock edge, reset included
`define HSVCS_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define HSVCS_ASSERT(label, prop, msg)
`define HSVCS_ASSERT_RST(label, prop, msg)
`endif

`endif

[rtl/hsvcs_pkg.sv]
// ----------------------------------------------------------------------------
// HSV colour shader package
// Shared types, constants and the restoring divider step.
// ----------------------------------------------------------------------------
package hsvcs_pkg;

	localparam logic [7:0] HUE_SECTOR = 8'd43;
	localparam logic [7:0] HUE_GREEN  = 8'd85;
	localparam logic [7:0] HUE_BLUE   = 8'd171;
	localparam logic [7:0] FULL_SCALE = 8'd255;

	// Quotients are 8 bits, one bit per divider stage
	localparam int DIV_STAGES = 8;

	typedef enum logic [2:0] {
		SHADE_NONE     = 3'd0,
		SHADE_DARKEST  = 3'd1,
		SHADE_DARKER   = 3'd2,
		SHADE_DARK     = 3'd3,
		SHADE_LIGHT    = 3'd4,
		SHADE_LIGHTER  = 3'd5,
		SHADE_LIGHTEST = 3'd6
	} shade_mode_t;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} max_sel_t;

	// Hue sectors of the six-region conversion
	typedef enum logic [2:0] {
		SECT_R_Y = 3'd0,
		SECT_Y_G = 3'd1,
		SECT_G_C = 3'd2,
		SECT_C_B = 3'd3,
		SECT_B_M = 3'd4,
		SECT_M_R = 3'd5
	} sector_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Partial remainder and shifting dividend/quotient word
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] quo;
	} div_lane_t;

	typedef struct packed {
		pix_t        pix;
		shade_mode_t mode;
		logic [7:0]  v;
		logic [7:0]  delta;
		max_sel_t    sel;
		logic        neg;
		logic        flat;
		div_lane_t   s_div;
		div_lane_t   h_div;
	} div_pl_t;

	// One restoring step: dividend below 256*d, so the remainder fits 8 bits
	function automatic div_lane_t div_step(div_lane_t x, logic [7:0] d);
		logic [8:0] part;
		div_lane_t  y;
		part = {x.rem, x.quo[7]};
		if (part >= {1'b0, d}) begin
			part  = part - {1'b0, d};
			y.quo = {x.quo[6:0], 1'b1};
		end else begin
			y.quo = {x.quo[6:0], 1'b0};
		end
		y.rem = part[7:0];
		return y;
	endfunction

endpackage

[rtl/hsvcs_front.sv]
// ----------------------------------------------------------------------------
// HSV colour shader front end
// Two stages: channel max/min and hue difference, then divider operands.
// ----------------------------------------------------------------------------
module hsvcs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hsvcs_pkg::pix_t        in_pix,
	input  hsvcs_pkg::shade_mode_t in_mode,
	output logic                   out_valid,
	input  logic                   out_ready,
	output hsvcs_pkg::div_pl_t     out_pl
);

	logic                   valid_s1, valid_s2;
	logic                   ready_s1, ready_s2;
	hsvcs_pkg::pix_t        pix_s1;
	hsvcs_pkg::shade_mode_t mode_s1;
	logic [7:0]             mx_s1, mn_s1;
	hsvcs_pkg::max_sel_t    sel_s1;
	logic [8:0]             diff_s1;
	hsvcs_pkg::div_pl_t     pl_s2;

	logic [7:0]          mx, mn;
	hsvcs_pkg::max_sel_t sel;
	logic [8:0]          diff;
	logic [7:0]          delta, mag;
	logic [15:0]         s_num, h_num;

	// Stage handshake
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// Max, min and the signed difference of the two other channels
	always_comb begin
		mx = in_pix.red;
		mn = in_pix.red;
		if (in_pix.green > mx) mx = in_pix.green;
		if (in_pix.blue > mx) mx = in_pix.blue;
		if (in_pix.green < mn) mn = in_pix.green;
		if (in_pix.blue < mn) mn = in_pix.blue;
		if (mx == in_pix.red) begin
			sel  = hsvcs_pkg::MAX_RED;
			diff = {1'b0, in_pix.green} - {1'b0, in_pix.blue};
		end else if (mx == in_pix.green) begin
			sel  = hsvcs_pkg::MAX_GREEN;
			diff = {1'b0, in_pix.blue} - {1'b0, in_pix.red};
		end else begin
			sel  = hsvcs_pkg::MAX_BLUE;
			diff = {1'b0, in_pix.red} - {1'b0, in_pix.green};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			pix_s1  <= in_pix;
			mode_s1 <= in_mode;
			mx_s1   <= mx;
			mn_s1   <= mn;
			sel_s1  <= sel;
			diff_s1 <= diff;
		end
	end

	// Divider operands: 255*delta over max, 43*|diff| over delta
	always_comb begin
		delta = mx_s1 - mn_s1;
		mag   = diff_s1[8] ? 8'(9'd0 - diff_s1) : diff_s1[7:0];
		s_num = {delta, 8'd0} - {8'd0, delta};
		h_num = ({8'd0, mag} << 5) + ({8'd0, mag} << 3) + ({8'd0, mag} << 1)
			+ {8'd0, mag};
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			pl_s2.pix       <= pix_s1;
			pl_s2.mode      <= mode_s1;
			pl_s2.v         <= mx_s1;
			pl_s2.delta     <= delta;
			pl_s2.sel       <= sel_s1;
			pl_s2.neg       <= diff_s1[8];
			pl_s2.flat      <= (delta == 8'd0);
			pl_s2.s_div.rem <= s_num[15:8];
			pl_s2.s_div.quo <= s_num[7:0];
			pl_s2.h_div.rem <= h_num[15:8];
			pl_s2.h_div.quo <= h_num[7:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_pl    = pl_s2;

endmodule

[rtl/hsvcs_div_stage.sv]
// ----------------------------------------------------------------------------
// HSV colour shader divider stage
// One quotient bit each for the saturation and hue divisions.
// ----------------------------------------------------------------------------
module hsvcs_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsvcs_pkg::div_pl_t in_pl,
	output logic               out_valid,
	input  logic               out_ready,
	output hsvcs_pkg::div_pl_t out_pl
);

	logic               valid_s1;
	hsvcs_pkg::div_pl_t pl_s1;
	hsvcs_pkg::div_pl_t pl_next;

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Saturation divides by max, hue by delta
	always_comb begin
		pl_next       = in_pl;
		pl_next.s_div = hsvcs_pkg::div_step(in_pl.s_div, in_pl.v);
		pl_next.h_div = hsvcs_pkg::div_step(in_pl.h_div, in_pl.delta);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pl_s1 <= pl_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_pl    = pl_s1;

endmodule

[rtl/hsvcs_back.sv]
// ----------------------------------------------------------------------------
// HSV colour shader back end
// Hue and scaling, sector split, products, and the output register.
// ----------------------------------------------------------------------------
`include "hsv_color_shader_core_macros.svh"

module hsvcs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsvcs_pkg::div_pl_t in_pl,
	output logic               out_valid,
	input  logic               out_ready,
	output hsvcs_pkg::pix_t    out_pix
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic load_s4;

	hsvcs_pkg::pix_t    pix_s1, pix_s2, pix_s3, pix_s4;
	logic               pass_s1, pass_s2, pass_s3;
	logic [7:0]         v_s1, v_s2, v_s3;
	logic [7:0]         s_s1, s_s2, s_s3;
	logic [7:0]         h_s1;
	hsvcs_pkg::sector_t sect_s2, sect_s3;
	logic [7:0]         rem_s2;
	logic [7:0]         p_s3, sr_s3, st_s3;

	logic [7:0]         off, sq, hue, vs, ss;
	logic [9:0]         v3, s3;
	logic               pass;
	hsvcs_pkg::sector_t sect;
	logic [7:0]         base, frac, rem;
	logic [15:0]        p_prod, sr_prod, st_prod, q_prod, t_prod;
	logic [7:0]         q, t;
	hsvcs_pkg::pix_t    res;

	// Stage handshake
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign load_s4  = valid_s3 && ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Hue with sign and offset, wraps mod 256; quarter-step scaling of V or S
	always_comb begin
		case (in_pl.sel)
			hsvcs_pkg::MAX_GREEN: off = hsvcs_pkg::HUE_GREEN;
			hsvcs_pkg::MAX_BLUE:  off = hsvcs_pkg::HUE_BLUE;
			default:              off = 8'd0;
		endcase
		sq  = in_pl.neg ? (8'd0 - in_pl.h_div.quo) : in_pl.h_div.quo;
		hue = off + sq;
		ss  = in_pl.flat ? 8'd0 : in_pl.s_div.quo;
		vs  = in_pl.v;
		v3  = {2'b00, in_pl.v} + {1'b0, in_pl.v, 1'b0};
		s3  = {2'b00, ss} + {1'b0, ss, 1'b0};
		pass = 1'b0;
		case (in_pl.mode)
			hsvcs_pkg::SHADE_DARKEST:  vs = in_pl.v >> 2;
			hsvcs_pkg::SHADE_DARKER:   vs = in_pl.v >> 1;
			hsvcs_pkg::SHADE_DARK:     vs = v3[9:2];
			hsvcs_pkg::SHADE_LIGHT:    ss = s3[9:2];
			hsvcs_pkg::SHADE_LIGHTER:  ss = ss >> 1;
			hsvcs_pkg::SHADE_LIGHTEST: ss = ss >> 2;
			default:                   pass = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			pix_s1  <= in_pl.pix;
			pass_s1 <= pass;
			v_s1    <= vs;
			s_s1    <= ss;
			h_s1    <= hue;
		end
	end

	// Sector is hue/43 by compares; remainder scaled by six
	always_comb begin
		if (h_s1 < 8'd43) begin
			sect = hsvcs_pkg::SECT_R_Y;
			base = 8'd0;
		end else if (h_s1 < 8'd86) begin
			sect = hsvcs_pkg::SECT_Y_G;
			base = hsvcs_pkg::HUE_SECTOR;
		end else if (h_s1 < 8'd129) begin
			sect = hsvcs_pkg::SECT_G_C;
			base = 8'd86;
		end else if (h_s1 < 8'd172) begin
			sect = hsvcs_pkg::SECT_C_B;
			base = 8'd129;
		end else if (h_s1 < 8'd215) begin
			sect = hsvcs_pkg::SECT_B_M;
			base = 8'd172;
		end else begin
			sect = hsvcs_pkg::SECT_M_R;
			base = 8'd215;
		end
		frac = h_s1 - base;
		rem  = (frac << 2) + (frac << 1);
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			pix_s2  <= pix_s1;
			pass_s2 <= pass_s1;
			v_s2    <= v_s1;
			s_s2    <= s_s1;
			sect_s2 <= sect;
			rem_s2  <= rem;
		end
	end

	// First products
	always_comb begin
		p_prod  = v_s2 * (hsvcs_pkg::FULL_SCALE - s_s2);
		sr_prod = s_s2 * rem_s2;
		st_prod = s_s2 * (hsvcs_pkg::FULL_SCALE - rem_s2);
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			pix_s3  <= pix_s2;
			pass_s3 <= pass_s2;
			v_s3    <= v_s2;
			s_s3    <= s_s2;
			sect_s3 <= sect_s2;
			p_s3    <= p_prod[15:8];
			sr_s3   <= sr_prod[15:8];
			st_s3   <= st_prod[15:8];
		end
	end

	// Second products and the sector select
	always_comb begin
		q_prod    = v_s3 * (hsvcs_pkg::FULL_SCALE - sr_s3);
		t_prod    = v_s3 * (hsvcs_pkg::FULL_SCALE - st_s3);
		q         = q_prod[15:8];
		t         = t_prod[15:8];
		res.alpha = pix_s3.alpha;
		if (pass_s3) begin
			res = pix_s3;
		end else if (s_s3 == 8'd0) begin
			res.red   = v_s3;
			res.green = v_s3;
			res.blue  = v_s3;
		end else begin
			case (sect_s3)
				hsvcs_pkg::SECT_R_Y: begin
					res.red = v_s3; res.green = t;    res.blue = p_s3;
				end
				hsvcs_pkg::SECT_Y_G: begin
					res.red = q;    res.green = v_s3; res.blue = p_s3;
				end
				hsvcs_pkg::SECT_G_C: begin
					res.red = p_s3; res.green = v_s3; res.blue = t;
				end
				hsvcs_pkg::SECT_C_B: begin
					res.red = p_s3; res.green = q;    res.blue = v_s3;
				end
				hsvcs_pkg::SECT_B_M: begin
					res.red = t;    res.green = p_s3; res.blue = v_s3;
				end
				default: begin
					res.red = v_s3; res.green = p_s3; res.blue = q;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_s4) begin
			pix_s4 <= res;
		end
	end

	assign out_valid = valid_s4;
	assign out_pix   = pix_s4;

	`HSVCS_ASSERT(a_grey_when_unsat, load_s4 && !pass_s3 && s_s3 == 8'd0 |=> pix_s4.red == pix_s4.green && pix_s4.green == pix_s4.blue, "unsaturated pixel is not grey")
	`HSVCS_ASSERT(a_pass_through, load_s4 && pass_s3 |=> pix_s4 == $past(pix_s3), "pass-through pixel altered")
	`HSVCS_ASSERT(a_value_kept, load_s4 && !pass_s3 |=> pix_s4.red == $past(v_s3) || pix_s4.green == $past(v_s3) || pix_s4.blue == $past(v_s3), "no channel carries V")
	`HSVCS_ASSERT_RST(a_idle_in_reset, !arst_n |=> !valid_s4, "output valid during reset")

endmodule

[rtl/hsv_color_shader_core.sv]
// ----------------------------------------------------------------------------
// HSV colour shader core
// Shades one ARGB pixel in 8-bit HSV space per request.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless back-pressure holds it up, and returns one
// shaded pixel per request, in order, through two front stages for
// max/min and the divider operands, eight divider stages (one quotient bit
// each for saturation and hue) and four back stages for hue, scaling, the
// two rounds of 8x8 products and the output register. Every stage holds its
// own valid bit, so bubbles close up under back-pressure and a stalled
// output does not stop requests while a stage further up is empty.
module hsv_color_shader_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] alpha_in,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [2:0] shade_mode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] alpha_out,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	hsvcs_pkg::pix_t    in_pix;
	hsvcs_pkg::pix_t    res_pix;
	hsvcs_pkg::div_pl_t div_pl    [hsvcs_pkg::DIV_STAGES+1];
	logic               div_valid [hsvcs_pkg::DIV_STAGES+1];
	logic               div_ready [hsvcs_pkg::DIV_STAGES+1];

	assign in_pix.alpha = alpha_in;
	assign in_pix.red   = red_in;
	assign in_pix.green = green_in;
	assign in_pix.blue  = blue_in;

	hsvcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_pix    (in_pix),
		.in_mode   (hsvcs_pkg::shade_mode_t'(shade_mode)),
		.out_valid (div_valid[0]),
		.out_ready (div_ready[0]),
		.out_pl    (div_pl[0])
	);

	// Divider pipeline, one quotient bit per stage
	for (genvar i = 0; i < hsvcs_pkg::DIV_STAGES; i++) begin : g_div
		hsvcs_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[i]),
			.in_ready  (div_ready[i]),
			.in_pl     (div_pl[i]),
			.out_valid (div_valid[i+1]),
			.out_ready (div_ready[i+1]),
			.out_pl    (div_pl[i+1])
		);
	end

	hsvcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[hsvcs_pkg::DIV_STAGES]),
		.in_ready  (div_ready[hsvcs_pkg::DIV_STAGES]),
		.in_pl     (div_pl[hsvcs_pkg::DIV_STAGES]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pix   (res_pix)
	);

	assign alpha_out = res_pix.alpha;
	assign red_out   = res_pix.red;
	assign green_out = res_pix.green;
	assign blue_out  = res_pix.blue;

endmodule

[sim/hsv_shade_checker.sv]
// ----------------------------------------------------------------------------
// HSV colour shader checker
// Watches both channels, predicts each shaded pixel and compares it in order.
// ----------------------------------------------------------------------------
module hsv_shade_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] alpha_in,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [2:0] shade_mode,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] alpha_out,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	output int         fail_count,
	output int         pixels_pending,
	output int         pixels_checked
);

	// Signed working copies of the hue constants
	localparam int SECTOR_W = hsvcs_pkg::HUE_SECTOR;
	localparam int GREEN_W  = hsvcs_pkg::HUE_GREEN;
	localparam int BLUE_W   = hsvcs_pkg::HUE_BLUE;
	localparam int FULL_W   = hsvcs_pkg::FULL_SCALE;

	hsvcs_pkg::pix_t shaded_expected[$];

	// Shade one pixel: RGB to HSV, scale V or S by quarters, back to RGB
	function automatic hsvcs_pkg::pix_t shade_pixel(hsvcs_pkg::pix_t px,
			logic [2:0] mode);
		int   r, g, b, hi, lo, span, hue_raw, sat, val, sector, frac, p, q, t;
		logic [7:0] hue;
		hsvcs_pkg::pix_t res;
		res = px;
		if (mode == hsvcs_pkg::SHADE_NONE || mode > hsvcs_pkg::SHADE_LIGHTEST)
			return res;
		r = px.red;
		g = px.green;
		b = px.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		span = hi - lo;
		val = hi;
		sat = 0;
		hue = 8'd0;
		// hue division truncates toward zero, then wraps to 8 bits
		if (span != 0) begin
			sat = (FULL_W * span) / hi;
			if (hi == r)
				hue_raw = (SECTOR_W * (g - b)) / span;
			else if (hi == g)
				hue_raw = GREEN_W + (SECTOR_W * (b - r)) / span;
			else
				hue_raw = BLUE_W + (SECTOR_W * (r - g)) / span;
			hue = hue_raw[7:0];
		end
		case (mode)
			hsvcs_pkg::SHADE_DARKEST:  val = (val * 1) >> 2;
			hsvcs_pkg::SHADE_DARKER:   val = (val * 2) >> 2;
			hsvcs_pkg::SHADE_DARK:     val = (val * 3) >> 2;
			hsvcs_pkg::SHADE_LIGHT:    sat = (sat * 3) >> 2;
			hsvcs_pkg::SHADE_LIGHTER:  sat = (sat * 2) >> 2;
			default:                   sat = (sat * 1) >> 2;
		endcase
		// no saturation left: grey at v
		if (sat == 0) begin
			res.red   = val[7:0];
			res.green = val[7:0];
			res.blue  = val[7:0];
			return res;
		end
		sector = int'(hue) / SECTOR_W;
		frac = (int'(hue) - sector * SECTOR_W) * 6;
		p = (val * (FULL_W - sat)) >> 8;
		q = (val * (FULL_W - ((sat * frac) >> 8))) >> 8;
		t = (val * (FULL_W - ((sat * (FULL_W - frac)) >> 8))) >> 8;
		case (sector)
			hsvcs_pkg::SECT_R_Y: begin
				res.red = val[7:0]; res.green = t[7:0];   res.blue = p[7:0];
			end
			hsvcs_pkg::SECT_Y_G: begin
				res.red = q[7:0];   res.green = val[7:0]; res.blue = p[7:0];
			end
			hsvcs_pkg::SECT_G_C: begin
				res.red = p[7:0];   res.green = val[7:0]; res.blue = t[7:0];
			end
			hsvcs_pkg::SECT_C_B: begin
				res.red = p[7:0];   res.green = q[7:0];   res.blue = val[7:0];
			end
			hsvcs_pkg::SECT_B_M: begin
				res.red = t[7:0];   res.green = p[7:0];   res.blue = val[7:0];
			end
			default: begin
				res.red = val[7:0]; res.green = p[7:0];   res.blue = q[7:0];
			end
		endcase
		return res;
	endfunction

	task automatic report_error(input string msg);
		$display("checker: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(input string field, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s got %02h want %02h",
				pixels_checked, field, got, want));
	endtask

	// Results pop and compare the oldest prediction, requests push a new one
	always @(posedge clk) begin
		hsvcs_pkg::pix_t px;
		hsvcs_pkg::pix_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (shaded_expected.size() == 0) begin
					report_error($sformatf("unexpected result %02h%02h%02h%02h",
						alpha_out, red_out, green_out, blue_out));
				end else begin
					want = shaded_expected.pop_front();
					check_field("alpha", alpha_out, want.alpha);
					check_field("red",   red_out,   want.red);
					check_field("green", green_out, want.green);
					check_field("blue",  blue_out,  want.blue);
				end
				pixels_checked++;
			end
			if (in_valid && in_ready) begin
				px.alpha = alpha_in;
				px.red   = red_in;
				px.green = green_in;
				px.blue  = blue_in;
				shaded_expected.push_back(shade_pixel(px, shade_mode));
			end
			pixels_pending = shaded_expected.size();
		end
	end

endmodule

[sim/tb_hsv_color_shader_core.sv]
// ----------------------------------------------------------------------------
// HSV colour shader testbench
// Drives directed and random pixels with random gaps and back-pressure; the
// checker predicts every shaded pixel and compares results in order.
// ----------------------------------------------------------------------------
module tb_hsv_color_shader_core;

	localparam logic [2:0] SHADE_SPARE = 3'd7;
	localparam int RANDOM_PIXELS  = 1880;
	localparam int CALM_PIXELS    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] alpha_in = 8'd0;
	logic [7:0] red_in = 8'd0;
	logic [7:0] green_in = 8'd0;
	logic [7:0] blue_in = 8'd0;
	logic [2:0] shade_mode = hsvcs_pkg::SHADE_NONE;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] alpha_out;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	int fail_count;
	int pixels_pending;
	int pixels_checked;

	logic in_taken = 1'b0;
	bit   idling_on = 1'b0;
	int   quiet_cycles = 0;
	int   pixels_sent = 0;
	int   flat_sent = 0;
	int   stall_left = 0;

	always #2 clk = ~clk;

	hsv_color_shader_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.alpha_in  (alpha_in),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.shade_mode(shade_mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.alpha_out (alpha_out),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	hsv_shade_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.alpha_in      (alpha_in),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.shade_mode    (shade_mode),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.alpha_out     (alpha_out),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.fail_count    (fail_count),
		.pixels_pending(pixels_pending),
		.pixels_checked(pixels_checked)
	);

	// Mostly short gaps, now and then a long one
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		if (pick < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Channel values lean towards the ends of the range
	function automatic logic [7:0] channel_value();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(0, 3));
			3: return 8'($urandom_range(252, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Request acceptance, seen at the edge and read back at the falling edge; handshake watchdog
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stalls while idling is on
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			if (idling_on && $urandom_range(0, 3) == 0)
				stall_left = gap_length();
		end
	end

	task automatic send_pixel(input logic [7:0] a, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [2:0] mode);
		int gap;
		gap = idling_on ? gap_length() : 0;
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		alpha_in   = a;
		red_in     = r;
		green_in   = g;
		blue_in    = b;
		shade_mode = mode;
		in_valid   = 1'b1;
		do @(negedge clk); while (!in_taken);
		pixels_sent++;
		if (r == g && g == b)
			flat_sent++;
	endtask

	task automatic send_random_pixel();
		logic [7:0] r, g, b;
		int kind;
		kind = $urandom_range(0, 99);
		r = channel_value();
		g = channel_value();
		b = channel_value();
		if (kind < 15) begin
			// flat pixel
			g = r;
			b = r;
		end else if (kind < 25) begin
			// nearly flat, small spans stress the divisions
			g = r ^ 8'($urandom_range(0, 3));
			b = r ^ 8'($urandom_range(0, 3));
		end
		send_pixel(8'($urandom_range(0, 255)), r, g, b, 3'($urandom_range(0, 7)));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, primaries, hue wrap, flat and spare mode
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00, hsvcs_pkg::SHADE_NONE);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, hsvcs_pkg::SHADE_DARKEST);
		send_pixel(8'hFF, 8'hFF, 8'h00, 8'h00, hsvcs_pkg::SHADE_DARKER);
		send_pixel(8'h00, 8'h00, 8'hFF, 8'h00, hsvcs_pkg::SHADE_DARK);
		send_pixel(8'h80, 8'h00, 8'h00, 8'hFF, hsvcs_pkg::SHADE_LIGHT);
		send_pixel(8'h7F, 8'hFF, 8'h00, 8'hFF, hsvcs_pkg::SHADE_LIGHTER);
		send_pixel(8'h01, 8'hC8, 8'h0A, 8'h0B, hsvcs_pkg::SHADE_LIGHTEST);
		send_pixel(8'hFE, 8'h64, 8'h00, 8'h03, hsvcs_pkg::SHADE_LIGHTEST);
		send_pixel(8'h55, 8'h00, 8'hFF, 8'hFF, hsvcs_pkg::SHADE_LIGHT);
		send_pixel(8'hAA, 8'h7F, 8'h7F, 8'h7F, hsvcs_pkg::SHADE_LIGHT);
		send_pixel(8'h33, 8'hFF, 8'hFF, 8'h00, hsvcs_pkg::SHADE_LIGHTER);
		send_pixel(8'hCC, 8'hFF, 8'hFE, 8'hFE, hsvcs_pkg::SHADE_LIGHTEST);
		send_pixel(8'hFF, 8'h01, 8'h00, 8'h00, hsvcs_pkg::SHADE_DARKEST);
		send_pixel(8'h0F, 8'h00, 8'h01, 8'hFF, hsvcs_pkg::SHADE_DARK);
		send_pixel(8'hF0, 8'hA5, 8'h5A, 8'h3C, SHADE_SPARE);
		for (int m = 0; m < 8; m++)
			send_pixel(8'h5A, 8'h12, 8'h9A, 8'hCD, 3'(m));

		// Back to back with no stalls on either side
		for (int i = 0; i < CALM_PIXELS; i++)
			send_random_pixel();

		// Hold off until the pipeline has drained
		in_valid = 1'b0;
		while (pixels_pending != 0) @(negedge clk);

		idling_on = 1'b1;
		for (int i = CALM_PIXELS; i < RANDOM_PIXELS; i++) begin
			send_random_pixel();
			// an occasional stretch without idling
			if (i % 400 == 0)
				idling_on = ~idling_on;
		end
		in_valid = 1'b0;

		while (pixels_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("summary: %0d pixels sent, %0d of them flat, every mode code incl. spare",
			pixels_sent, flat_sent);
		$display("summary: %0d results checked under random gaps and back-pressure",
			pixels_checked);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/hsvcs_pkg.sv
rtl/hsvcs_front.sv
rtl/hsvcs_div_stage.sv
rtl/hsvcs_back.sv
rtl/hsv_color_shader_core.sv
sim/hsv_shade_checker.sv
sim/tb_hsv_color_shader_core.sv
